/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tsm_pkg.sv */
// Shared constants, types and arithmetic helpers of the texture sampler.
package tsm_pkg;

    localparam int MAX_DIM     = 128;
    localparam int MAX_LEVELS  = 7;
    localparam int STORE_DEPTH = 32768;
    localparam int LEVEL_SLOTS = MAX_LEVELS + 1;

    localparam int DIM_W      = 8;
    localparam int LVL_W      = 3;
    localparam int FADDR_W    = 16;
    localparam int CH_W       = 16;
    localparam int TEXEL_W    = 3 * CH_W;
    localparam int COORD_W    = 18;
    localparam int UNIT_W     = 17;
    localparam int LOD_W      = 13;
    localparam int POS_W      = 7;
    localparam int WGT_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = DIM_W + UNIT_W;
    localparam int FL_W       = PROD_W - WGT_W;
    localparam int ROW_W      = POS_W + DIM_W;
    localparam int NUM_TAPS   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int HALF_TEXEL = 32768;
    localparam int UNIT_ONE   = 65536;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT  = 2'd2;

    localparam logic [1:0] SMODE_NEAREST = 2'd0;

    typedef logic [DIM_W-1:0] dim_t;

    typedef struct packed {
        logic [1:0] sampler_mode;
        dim_t       width;
        dim_t       height;
    } cfg_t;

    typedef struct packed {
        logic                         empty;
        logic [LVL_W-1:0]             top;
        logic [LEVEL_SLOTS-1:0][DIM_W-1:0] lw;
        logic [LEVEL_SLOTS-1:0][DIM_W-1:0] lh;
    } lvl_t;

    typedef logic [LEVEL_SLOTS-1:0][FADDR_W-1:0] base_t;

    typedef struct packed {
        logic [POS_W-1:0] i0;
        logic [POS_W-1:0] i1;
        logic [WGT_W-1:0] w;
    } axis_t;

    typedef struct packed {
        logic                        valid;
        logic                        empty;
        logic [FRAC_W-1:0]           f;
        logic [1:0][WGT_W-1:0]       wx;
        logic [1:0][WGT_W-1:0]       wy;
        logic [NUM_TAPS-1:0]         hit;
    } tap_t;

    // Blend two channels with a Q0.16 weight, round to nearest.
    function automatic logic [CH_W-1:0] lerp16(input logic [CH_W-1:0] p,
                                               input logic [CH_W-1:0] q,
                                               input logic [WGT_W-1:0] w);
        logic signed [CH_W:0]          d;
        logic signed [CH_W+WGT_W+1:0]  s;
        logic signed [CH_W+WGT_W+1:0]  r;
        d = $signed({1'b0, q}) - $signed({1'b0, p});
        s = d * $signed({1'b0, w}) + $signed((CH_W+WGT_W+2)'(HALF_TEXEL));
        r = (s >>> WGT_W) + $signed((CH_W+WGT_W+2)'(p));
        return r[CH_W-1:0];
    endfunction

    // Blend two channels with an 8-bit fraction, round to nearest.
    function automatic logic [CH_W-1:0] lerp8(input logic [CH_W-1:0] p,
                                              input logic [CH_W-1:0] q,
                                              input logic [FRAC_W-1:0] f);
        logic signed [CH_W:0]           d;
        logic signed [CH_W+FRAC_W+1:0]  s;
        logic signed [CH_W+FRAC_W+1:0]  r;
        d = $signed({1'b0, q}) - $signed({1'b0, p});
        s = d * $signed({1'b0, f}) + $signed((CH_W+FRAC_W+2)'(128));
        r = (s >>> FRAC_W) + $signed((CH_W+FRAC_W+2)'(p));
        return r[CH_W-1:0];
    endfunction

    // Turn dim * coord into two neighbor indices and a weight.
    function automatic axis_t axis_pos(input logic [DIM_W-1:0] dim,
                                       input logic [PROD_W-1:0] prod,
                                       input logic nearest);
        axis_t             r;
        logic [PROD_W-1:0] x;
        logic [FL_W-1:0]   fl;
        logic [FL_W-1:0]   lim;
        r   = '0;
        lim = FL_W'(dim) - FL_W'(1);
        x   = prod - PROD_W'(HALF_TEXEL);
        fl  = x[PROD_W-1:WGT_W];
        if (nearest) begin
            fl = prod[PROD_W-1:WGT_W];
            if (fl > lim) fl = lim;
            r.i0 = POS_W'(fl);
            r.i1 = POS_W'(fl);
        end else if (prod >= PROD_W'(HALF_TEXEL)) begin
            if (fl >= lim) begin
                r.i0 = POS_W'(lim);
                r.i1 = POS_W'(lim);
            end else begin
                r.i0 = POS_W'(fl);
                r.i1 = POS_W'(fl + FL_W'(1));
                r.w  = x[WGT_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

/* sv/tsm_ram.sv */
// Generic RAM: one write port, two registered read ports, read-first.
module tsm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd_en,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents at both addresses
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

/* sv/tsm_front.sv */
// Front pipeline: level select, axis setup, texel addresses and store writes.
module tsm_front #(
    parameter int STORE_DEPTH = tsm_pkg::STORE_DEPTH,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   in_valid,
    input  logic                                   mode,
    input  logic signed [tsm_pkg::COORD_W-1:0]     coord_u,
    input  logic signed [tsm_pkg::COORD_W-1:0]     coord_v,
    input  logic signed [tsm_pkg::LOD_W-1:0]       detail_level,
    input  logic [tsm_pkg::LVL_W-1:0]              load_level,
    input  logic [tsm_pkg::POS_W-1:0]              load_x,
    input  logic [tsm_pkg::POS_W-1:0]              load_y,
    input  logic [tsm_pkg::CH_W-1:0]               in_red,
    input  logic [tsm_pkg::CH_W-1:0]               in_green,
    input  logic [tsm_pkg::CH_W-1:0]               in_blue,
    input  tsm_pkg::cfg_t                          cfg,
    input  tsm_pkg::lvl_t                          lvl,
    input  tsm_pkg::base_t                         base,
    output logic [tsm_pkg::NUM_TAPS-1:0][AW-1:0]   rd_addr,
    output logic                                   wr_en,
    output logic [AW-1:0]                          wr_addr,
    output logic [tsm_pkg::TEXEL_W-1:0]            wr_data,
    output tsm_pkg::tap_t                          tap
);

    // Stage 1: input register
    logic                              s1_valid_reg;
    logic                              s1_load_reg;
    logic signed [tsm_pkg::COORD_W-1:0] s1_u_reg, s1_v_reg;
    logic signed [tsm_pkg::LOD_W-1:0]  s1_lod_reg;
    logic [tsm_pkg::LVL_W-1:0]         s1_lvl_reg;
    logic [tsm_pkg::POS_W-1:0]         s1_x_reg, s1_y_reg;
    logic [tsm_pkg::TEXEL_W-1:0]       s1_rgb_reg;

    // Stage 2: levels and coordinate products
    logic                              s2_valid_reg, s2_load_reg, s2_ok_reg;
    logic                              s2_near_reg, s2_empty_reg;
    logic [tsm_pkg::LVL_W-1:0]         s2_ka_reg, s2_kb_reg;
    logic [tsm_pkg::FRAC_W-1:0]        s2_f_reg;
    logic [1:0][tsm_pkg::PROD_W-1:0]   s2_px_reg, s2_py_reg;
    logic [1:0][tsm_pkg::DIM_W-1:0]    s2_w_reg, s2_h_reg;
    logic [tsm_pkg::POS_W-1:0]         s2_x_reg, s2_y_reg;
    logic [tsm_pkg::TEXEL_W-1:0]       s2_rgb_reg;

    // Stage 3: axis indices and weights
    logic                              s3_valid_reg, s3_load_reg, s3_ok_reg, s3_empty_reg;
    logic [tsm_pkg::LVL_W-1:0]         s3_ka_reg, s3_kb_reg;
    logic [tsm_pkg::FRAC_W-1:0]        s3_f_reg;
    tsm_pkg::axis_t [1:0]              s3_ax_reg, s3_ay_reg;
    logic [1:0][tsm_pkg::DIM_W-1:0]    s3_w_reg;
    logic [tsm_pkg::TEXEL_W-1:0]       s3_rgb_reg;

    // Stage 4: row offsets and level bases
    logic                              s4_valid_reg, s4_load_reg, s4_ok_reg, s4_empty_reg;
    logic [tsm_pkg::FRAC_W-1:0]        s4_f_reg;
    logic [1:0][1:0][tsm_pkg::ROW_W-1:0] s4_row_reg;
    logic [1:0][tsm_pkg::FADDR_W-1:0]  s4_base_reg;
    tsm_pkg::axis_t [1:0]              s4_ax_reg;
    logic [1:0][tsm_pkg::WGT_W-1:0]    s4_wy_reg;
    logic [tsm_pkg::TEXEL_W-1:0]       s4_rgb_reg;

    // Stage 5: aligned with RAM read data
    logic                              s5_valid_reg, s5_empty_reg;
    logic [tsm_pkg::FRAC_W-1:0]        s5_f_reg;
    logic [1:0][tsm_pkg::WGT_W-1:0]    s5_wx_reg, s5_wy_reg;
    logic [tsm_pkg::NUM_TAPS-1:0]      s5_hit_reg;

    // Stage 2 logic
    logic [tsm_pkg::UNIT_W-1:0]        u_clamp, v_clamp;
    logic [tsm_pkg::LVL_W-1:0]         ka, kb;
    logic [tsm_pkg::FRAC_W-1:0]        f_sel;
    logic [3:0]                        d1;
    logic                              load_ok;
    logic                              near_sel;

    always_comb
    begin
        u_clamp = s1_u_reg[tsm_pkg::UNIT_W-1:0];
        if (s1_u_reg[tsm_pkg::COORD_W-1])
            u_clamp = '0;
        else if (s1_u_reg[tsm_pkg::UNIT_W-1:0] > tsm_pkg::UNIT_W'(tsm_pkg::UNIT_ONE))
            u_clamp = tsm_pkg::UNIT_W'(tsm_pkg::UNIT_ONE);
        v_clamp = s1_v_reg[tsm_pkg::UNIT_W-1:0];
        if (s1_v_reg[tsm_pkg::COORD_W-1])
            v_clamp = '0;
        else if (s1_v_reg[tsm_pkg::UNIT_W-1:0] > tsm_pkg::UNIT_W'(tsm_pkg::UNIT_ONE))
            v_clamp = tsm_pkg::UNIT_W'(tsm_pkg::UNIT_ONE);

        near_sel = (cfg.sampler_mode == tsm_pkg::SMODE_NEAREST) && !s1_load_reg;
        d1       = s1_lod_reg[11:8];
        ka       = '0;
        kb       = '0;
        f_sel    = '0;
        if (s1_load_reg)
        begin
            ka = s1_lvl_reg;
            kb = s1_lvl_reg;
        end
        else if (cfg.sampler_mode[1] && !s1_lod_reg[tsm_pkg::LOD_W-1])
        begin
            if (d1 >= {1'b0, lvl.top})
            begin
                ka = lvl.top;
                kb = lvl.top;
            end
            else
            begin
                ka    = d1[tsm_pkg::LVL_W-1:0];
                kb    = d1[tsm_pkg::LVL_W-1:0] + tsm_pkg::LVL_W'(1);
                f_sel = s1_lod_reg[tsm_pkg::FRAC_W-1:0];
            end
        end

        load_ok = !lvl.empty && (s1_lvl_reg <= lvl.top)
                  && ({1'b0, s1_x_reg} < lvl.lw[s1_lvl_reg])
                  && ({1'b0, s1_y_reg} < lvl.lh[s1_lvl_reg]);
    end

    // Stage 3 logic
    tsm_pkg::axis_t [1:0] ax, ay;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ax[l] = tsm_pkg::axis_pos(s2_w_reg[l], s2_px_reg[l], s2_near_reg);
            ay[l] = tsm_pkg::axis_pos(s2_h_reg[l], s2_py_reg[l], s2_near_reg);
        end
        if (s2_load_reg)
        begin
            ax[0].i0 = s2_x_reg;
            ay[0].i0 = s2_y_reg;
        end
    end

    // Stage 5 logic: texel addresses
    logic [tsm_pkg::NUM_TAPS-1:0][tsm_pkg::FADDR_W-1:0] addr;
    logic [tsm_pkg::NUM_TAPS-1:0]                       hit;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int r = 0; r < 2; r++)
            begin
                addr[4*l+2*r]   = s4_base_reg[l] + tsm_pkg::FADDR_W'(s4_row_reg[l][r])
                                  + tsm_pkg::FADDR_W'(s4_ax_reg[l].i0);
                addr[4*l+2*r+1] = s4_base_reg[l] + tsm_pkg::FADDR_W'(s4_row_reg[l][r])
                                  + tsm_pkg::FADDR_W'(s4_ax_reg[l].i1);
            end
        end
        for (int t = 0; t < tsm_pkg::NUM_TAPS; t++)
        begin
            hit[t]     = 33'(addr[t]) < 33'(STORE_DEPTH);
            rd_addr[t] = AW'(addr[t]);
        end
    end

    assign wr_en   = advance && s4_valid_reg && s4_load_reg && s4_ok_reg && hit[0];
    assign wr_addr = rd_addr[0];
    assign wr_data = s4_rgb_reg;

    // Pack the stage 5 fields for the filter
    always_comb
    begin
        tap.valid = s5_valid_reg;
        tap.empty = s5_empty_reg;
        tap.f     = s5_f_reg;
        tap.wx    = s5_wx_reg;
        tap.wy    = s5_wy_reg;
        tap.hit   = s5_hit_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg && !s4_load_reg;
        end
    end

    // Advance payload, hold on stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_load_reg <= mode;
            s1_u_reg    <= coord_u;
            s1_v_reg    <= coord_v;
            s1_lod_reg  <= detail_level;
            s1_lvl_reg  <= load_level;
            s1_x_reg    <= load_x;
            s1_y_reg    <= load_y;
            s1_rgb_reg  <= {in_blue, in_green, in_red};

            s2_load_reg  <= s1_load_reg;
            s2_ok_reg    <= load_ok;
            s2_near_reg  <= near_sel;
            s2_empty_reg <= lvl.empty;
            s2_ka_reg    <= ka;
            s2_kb_reg    <= kb;
            s2_f_reg     <= f_sel;
            s2_w_reg[0]  <= lvl.lw[ka];
            s2_w_reg[1]  <= lvl.lw[kb];
            s2_h_reg[0]  <= lvl.lh[ka];
            s2_h_reg[1]  <= lvl.lh[kb];
            s2_px_reg[0] <= tsm_pkg::PROD_W'(lvl.lw[ka]) * tsm_pkg::PROD_W'(u_clamp);
            s2_px_reg[1] <= tsm_pkg::PROD_W'(lvl.lw[kb]) * tsm_pkg::PROD_W'(u_clamp);
            s2_py_reg[0] <= tsm_pkg::PROD_W'(lvl.lh[ka]) * tsm_pkg::PROD_W'(v_clamp);
            s2_py_reg[1] <= tsm_pkg::PROD_W'(lvl.lh[kb]) * tsm_pkg::PROD_W'(v_clamp);
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_rgb_reg   <= s1_rgb_reg;

            s3_load_reg  <= s2_load_reg;
            s3_ok_reg    <= s2_ok_reg;
            s3_empty_reg <= s2_empty_reg;
            s3_ka_reg    <= s2_ka_reg;
            s3_kb_reg    <= s2_kb_reg;
            s3_f_reg     <= s2_f_reg;
            s3_ax_reg    <= ax;
            s3_ay_reg    <= ay;
            s3_w_reg     <= s2_w_reg;
            s3_rgb_reg   <= s2_rgb_reg;

            s4_load_reg  <= s3_load_reg;
            s4_ok_reg    <= s3_ok_reg;
            s4_empty_reg <= s3_empty_reg;
            s4_f_reg     <= s3_f_reg;
            for (int l = 0; l < 2; l++)
            begin
                s4_row_reg[l][0] <= tsm_pkg::ROW_W'(s3_ay_reg[l].i0)
                                    * tsm_pkg::ROW_W'(s3_w_reg[l]);
                s4_row_reg[l][1] <= tsm_pkg::ROW_W'(s3_ay_reg[l].i1)
                                    * tsm_pkg::ROW_W'(s3_w_reg[l]);
                s4_wy_reg[l]     <= s3_ay_reg[l].w;
            end
            s4_base_reg[0] <= base[s3_ka_reg];
            s4_base_reg[1] <= base[s3_kb_reg];
            s4_ax_reg      <= s3_ax_reg;
            s4_rgb_reg     <= s3_rgb_reg;

            s5_empty_reg <= s4_empty_reg;
            s5_f_reg     <= s4_f_reg;
            s5_wx_reg[0] <= s4_ax_reg[0].w;
            s5_wx_reg[1] <= s4_ax_reg[1].w;
            s5_wy_reg    <= s4_wy_reg;
            s5_hit_reg   <= hit;
        end
    end

endmodule

/* sv/tsm_filter.sv */
// Filter pipeline: horizontal, vertical and level blends into the output register.
module tsm_filter (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  tsm_pkg::tap_t                                 tap,
    input  logic [tsm_pkg::NUM_TAPS-1:0][tsm_pkg::TEXEL_W-1:0] texel,
    output logic                                          out_valid,
    output logic [tsm_pkg::CH_W-1:0]                      out_red,
    output logic [tsm_pkg::CH_W-1:0]                      out_green,
    output logic [tsm_pkg::CH_W-1:0]                      out_blue
);

    logic                                   f1_valid_reg, f1_empty_reg;
    logic [tsm_pkg::FRAC_W-1:0]             f1_f_reg;
    logic [1:0][tsm_pkg::WGT_W-1:0]         f1_wy_reg;
    logic [1:0][1:0][2:0][tsm_pkg::CH_W-1:0] f1_h_reg;

    logic                                   f2_valid_reg, f2_empty_reg;
    logic [tsm_pkg::FRAC_W-1:0]             f2_f_reg;
    logic [1:0][2:0][tsm_pkg::CH_W-1:0]     f2_v_reg;

    logic                                   out_valid_reg;
    logic [2:0][tsm_pkg::CH_W-1:0]          out_rgb_reg;

    // Drop reads that fell outside the store, then blend each row horizontally
    logic [tsm_pkg::NUM_TAPS-1:0][tsm_pkg::TEXEL_W-1:0] t;
    logic [1:0][1:0][2:0][tsm_pkg::CH_W-1:0]           h;

    always_comb
    begin
        for (int i = 0; i < tsm_pkg::NUM_TAPS; i++)
            t[i] = tap.hit[i] ? texel[i] : '0;
        for (int l = 0; l < 2; l++)
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 3; c++)
                    h[l][r][c] = tsm_pkg::lerp16(t[4*l+2*r][c*tsm_pkg::CH_W +: tsm_pkg::CH_W],
                                                 t[4*l+2*r+1][c*tsm_pkg::CH_W +: tsm_pkg::CH_W],
                                                 tap.wx[l]);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg  <= tap.valid;
            f2_valid_reg  <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    // Blend rows, then levels
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_empty_reg <= tap.empty;
            f1_f_reg     <= tap.f;
            f1_wy_reg    <= tap.wy;
            f1_h_reg     <= h;

            f2_empty_reg <= f1_empty_reg;
            f2_f_reg     <= f1_f_reg;
            for (int l = 0; l < 2; l++)
                for (int c = 0; c < 3; c++)
                    f2_v_reg[l][c] <= tsm_pkg::lerp16(f1_h_reg[l][0][c], f1_h_reg[l][1][c],
                                                      f1_wy_reg[l]);

            for (int c = 0; c < 3; c++)
                out_rgb_reg[c] <= f2_empty_reg ? '0
                                  : tsm_pkg::lerp8(f2_v_reg[0][c], f2_v_reg[1][c], f2_f_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_rgb_reg[0];
    assign out_green = out_rgb_reg[1];
    assign out_blue  = out_rgb_reg[2];

endmodule

/* sv/texture_sampler_mip_filter_unit.sv */
// Top level of the mip-mapped texture sampler: config, level tables, store, pipelines.
//
// Input channel (in_valid / in_stall) takes one item per cycle while in_stall is
// low: a texel load (mode = 1) writes load_level/load_x/load_y with in_red/green/blue,
// a sample (mode = 0) takes coord_u, coord_v and detail_level. Each sample gives
// one item on the output channel (out_valid / out_stall); a load gives none.
// Throughput: one item per clock while out_stall holds no result, set by the
// eight-stage pipeline and four replicated texel RAMs with two read ports each,
// which serve all eight trilinear taps of a sample together.
// A sample passes front stages s1-s5 with the RAM read, filter stages f1 and f2,
// then the output register. Loads write the store from s4; later samples see them.
// Configuration: cfg_write_en with cfg_index (0 sampler mode, 1 base width,
// 2 base height) and cfg_data. Level tables are registered from them, bases from those.
// Reset clears configuration and all valid bits; the texel store is not
// cleared and must be loaded before it is sampled.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
module texture_sampler_mip_filter_unit #(
    parameter int STORE_DEPTH = tsm_pkg::STORE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [tsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic signed [tsm_pkg::COORD_W-1:0]  coord_u,
    input  logic signed [tsm_pkg::COORD_W-1:0]  coord_v,
    input  logic signed [tsm_pkg::LOD_W-1:0]    detail_level,
    input  logic [tsm_pkg::LVL_W-1:0]           load_level,
    input  logic [tsm_pkg::POS_W-1:0]           load_x,
    input  logic [tsm_pkg::POS_W-1:0]           load_y,
    input  logic [tsm_pkg::CH_W-1:0]            in_red,
    input  logic [tsm_pkg::CH_W-1:0]            in_green,
    input  logic [tsm_pkg::CH_W-1:0]            in_blue,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tsm_pkg::CH_W-1:0]            out_red,
    output logic [tsm_pkg::CH_W-1:0]            out_green,
    output logic [tsm_pkg::CH_W-1:0]            out_blue
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    tsm_pkg::cfg_t  cfg_reg;
    tsm_pkg::lvl_t  lvl_reg, lvl_next;
    tsm_pkg::base_t base_reg, base_next;
    logic           advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                tsm_pkg::REG_SAMPLER_MODE: cfg_reg.sampler_mode <= cfg_data[1:0];
                tsm_pkg::REG_BASE_WIDTH:   cfg_reg.width        <= cfg_data;
                tsm_pkg::REG_BASE_HEIGHT:  cfg_reg.height       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Derive level sizes and level count
    tsm_pkg::dim_t dw, dh, dm, sw, sh;

    always_comb
    begin
        dw = (cfg_reg.width > tsm_pkg::DIM_W'(tsm_pkg::MAX_DIM))
             ? tsm_pkg::DIM_W'(tsm_pkg::MAX_DIM) : cfg_reg.width;
        dh = (cfg_reg.height > tsm_pkg::DIM_W'(tsm_pkg::MAX_DIM))
             ? tsm_pkg::DIM_W'(tsm_pkg::MAX_DIM) : cfg_reg.height;
        dm = (dw > dh) ? dw : dh;
        lvl_next       = '0;
        lvl_next.empty = (dw == '0) || (dh == '0);
        for (int k = 0; k < tsm_pkg::LEVEL_SLOTS; k++)
        begin
            sw = dw >> k;
            sh = dh >> k;
            lvl_next.lw[k] = (sw == '0) ? tsm_pkg::DIM_W'(1) : sw;
            lvl_next.lh[k] = (sh == '0) ? tsm_pkg::DIM_W'(1) : sh;
        end
        for (int i = 1; i <= tsm_pkg::MAX_LEVELS; i++)
            if ((dm >> i) != '0)
                lvl_next.top = tsm_pkg::LVL_W'(i);
    end

    // Sum level sizes into level start addresses
    always_comb
    begin
        base_next[0] = '0;
        for (int k = 1; k < tsm_pkg::LEVEL_SLOTS; k++)
            base_next[k] = base_next[k-1]
                           + tsm_pkg::FADDR_W'(lvl_reg.lw[k-1])
                             * tsm_pkg::FADDR_W'(lvl_reg.lh[k-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            lvl_reg  <= lvl_next;
            base_reg <= base_next;
        end
    end

    // Move the pipeline unless a finished result is held
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    logic [tsm_pkg::NUM_TAPS-1:0][AW-1:0]              rd_addr;
    logic [tsm_pkg::NUM_TAPS-1:0][tsm_pkg::TEXEL_W-1:0] texel;
    logic                                              wr_en;
    logic [AW-1:0]                                     wr_addr;
    logic [tsm_pkg::TEXEL_W-1:0]                       wr_data;
    tsm_pkg::tap_t                                     tap;

    tsm_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (in_valid),
        .mode         (mode),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .detail_level (detail_level),
        .load_level   (load_level),
        .load_x       (load_x),
        .load_y       (load_y),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .cfg          (cfg_reg),
        .lvl          (lvl_reg),
        .base         (base_reg),
        .rd_addr      (rd_addr),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .tap          (tap)
    );

    // Replicate the store so every tap has a read port
    for (genvar j = 0; j < tsm_pkg::NUM_TAPS / 2; j++)
    begin : g_bank
        tsm_ram #(
            .WIDTH (tsm_pkg::TEXEL_W),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .clk    (clk),
            .we     (wr_en),
            .waddr  (wr_addr),
            .wdata  (wr_data),
            .rd_en  (advance),
            .raddr0 (rd_addr[2*j]),
            .raddr1 (rd_addr[2*j+1]),
            .rdata0 (texel[2*j]),
            .rdata1 (texel[2*j+1])
        );
    end

    tsm_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tap       (tap),
        .texel     (texel),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

endmodule

/* sv/tsm_checker.sv */
// Port checker for the texture sampler, bound to the top level.
`include "assert_macros.svh"

module tsm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tsm_pkg::CH_W-1:0]    out_red,
    input logic [tsm_pkg::CH_W-1:0]    out_green,
    input logic [tsm_pkg::CH_W-1:0]    out_blue
);

    // Hold a stalled result
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                 $stable(out_red) && $stable(out_green) && $stable(out_blue),
                 "stalled result changed")

    // Stall the input exactly when a result is held
    `ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")
    `ASSERT_SAME(a_stall_full, out_valid && out_stall, in_stall, "input taken while frozen")

endmodule

bind texture_sampler_mip_filter_unit tsm_checker u_tsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
);

/* bench/tb.sv */
// Self-checking testbench for the mip-mapped texture sampler.
`timescale 1ns / 1ps

module tb;
    import tsm_pkg::*;

    localparam logic [1:0] SM_BILINEAR  = 2'd1;
    localparam logic [1:0] SM_TRILINEAR = 2'd2;
    localparam logic [1:0] SM_TRI_ALT   = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 200;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } color_t;

    typedef struct packed {
        logic               mode;
        logic signed [17:0] u;
        logic signed [17:0] v;
        logic signed [12:0] lod;
        logic [2:0]         lvl;
        logic [6:0]         x;
        logic [6:0]         y;
        color_t             c;
    } req_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [1:0] reg_idx;
        logic [7:0] reg_val;
        req_t       req;
        logic       known;
        color_t     want;
    } row_t;

    typedef struct {
        int          i0;
        int          i1;
        int unsigned w;
    } span_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic signed [COORD_W-1:0] coord_u = '0;
    logic signed [COORD_W-1:0] coord_v = '0;
    logic signed [LOD_W-1:0] detail_level = '0;
    logic [LVL_W-1:0] load_level = '0;
    logic [POS_W-1:0] load_x = '0;
    logic [POS_W-1:0] load_y = '0;
    logic [CH_W-1:0] in_red = '0;
    logic [CH_W-1:0] in_green = '0;
    logic [CH_W-1:0] in_blue = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;

    texture_sampler_mip_filter_unit dut (.*);

    // Shadow copy of the sampler state
    color_t      texels [STORE_DEPTH];
    logic [1:0]  sh_mode = '0;
    int unsigned sh_w = 0;
    int unsigned sh_h = 0;

    color_t pending_colors [$];
    int     errors = 0;
    bit     quiet = 1'b0;
    bit     hold_req = 1'b0;
    int     idle_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Texture geometry
    function automatic int unsigned eff_w();
        return sh_w > MAX_DIM ? MAX_DIM : sh_w;
    endfunction

    function automatic int unsigned eff_h();
        return sh_h > MAX_DIM ? MAX_DIM : sh_h;
    endfunction

    function automatic int unsigned lvl_w(int unsigned k);
        int unsigned d;
        d = eff_w() >> k;
        return d != 0 ? d : 1;
    endfunction

    function automatic int unsigned lvl_h(int unsigned k);
        int unsigned d;
        d = eff_h() >> k;
        return d != 0 ? d : 1;
    endfunction

    function automatic int unsigned top_level();
        int unsigned m;
        int unsigned n;
        m = eff_w() > eff_h() ? eff_w() : eff_h();
        n = 0;
        while ((m >> 1) != 0 && n < MAX_LEVELS)
        begin
            m = m >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic int unsigned texel_addr(int unsigned k, int unsigned x, int unsigned y);
        int unsigned a;
        a = 0;
        for (int unsigned j = 0; j < k; j++)
            a += lvl_w(j) * lvl_h(j);
        return a + y * lvl_w(k) + x;
    endfunction

    function automatic color_t read_texel(int unsigned k, int unsigned x, int unsigned y);
        int unsigned a;
        a = texel_addr(k, x, y);
        return a >= STORE_DEPTH ? color_t'(0) : texels[a];
    endfunction

    // Filtering arithmetic
    function automatic logic [15:0] blend16(logic [15:0] p, logic [15:0] q, int unsigned w);
        longint unsigned s;
        s = longint'(p) * (65536 - w) + longint'(q) * w + 32768;
        return s[31:16];
    endfunction

    function automatic color_t mix16(color_t p, color_t q, int unsigned w);
        color_t r;
        r.red   = blend16(p.red, q.red, w);
        r.green = blend16(p.green, q.green, w);
        r.blue  = blend16(p.blue, q.blue, w);
        return r;
    endfunction

    function automatic logic [15:0] blend8(logic [15:0] p, logic [15:0] q, int unsigned f);
        longint unsigned s;
        s = longint'(p) * (256 - f) + longint'(q) * f + 128;
        return s[23:8];
    endfunction

    function automatic int unsigned clamp_unit(logic signed [17:0] c);
        if (c < 0)
            return 0;
        if (c > 65536)
            return 65536;
        return int'(c);
    endfunction

    function automatic span_t find_span(int unsigned dim, int unsigned c);
        longint x;
        longint fl;
        span_t  s;
        x = longint'(dim) * c - 32768;
        if (x < 0)
            return '{0, 0, 0};
        fl = x >>> 16;
        if (fl >= dim - 1)
        begin
            s = '{dim - 1, dim - 1, 0};
            return s;
        end
        s = '{int'(fl), int'(fl) + 1, int'(x & 65535)};
        return s;
    endfunction

    function automatic color_t bilinear_at(int unsigned k, int unsigned u, int unsigned v);
        span_t sx;
        span_t sy;
        sx = find_span(lvl_w(k), u);
        sy = find_span(lvl_h(k), v);
        return mix16(mix16(read_texel(k, sx.i0, sy.i0), read_texel(k, sx.i1, sy.i0), sx.w),
                     mix16(read_texel(k, sx.i0, sy.i1), read_texel(k, sx.i1, sy.i1), sx.w),
                     sy.w);
    endfunction

    function automatic color_t filtered_color(req_t q);
        int unsigned u;
        int unsigned v;
        int unsigned ix;
        int unsigned iy;
        int unsigned d1;
        int unsigned f;
        color_t lo;
        color_t hi;
        color_t r;
        if (eff_w() == 0 || eff_h() == 0)
            return '0;
        u = clamp_unit(q.u);
        v = clamp_unit(q.v);
        if (sh_mode == SMODE_NEAREST)
        begin
            ix = (eff_w() * u) >> 16;
            iy = (eff_h() * v) >> 16;
            if (ix > eff_w() - 1) ix = eff_w() - 1;
            if (iy > eff_h() - 1) iy = eff_h() - 1;
            return read_texel(0, ix, iy);
        end
        if (sh_mode == SM_BILINEAR || q.lod < 0)
            return bilinear_at(0, u, v);
        d1 = int'(q.lod) >> 8;
        f  = int'(q.lod) & 255;
        if (d1 >= top_level())
            return bilinear_at(top_level(), u, v);
        lo = bilinear_at(d1, u, v);
        hi = bilinear_at(d1 + 1, u, v);
        r.red   = blend8(lo.red, hi.red, f);
        r.green = blend8(lo.green, hi.green, f);
        r.blue  = blend8(lo.blue, hi.blue, f);
        return r;
    endfunction

    // Apply one accepted item to the shadow state
    task automatic absorb(req_t q, bit known, color_t want);
        if (q.mode)
        begin
            if (eff_w() != 0 && eff_h() != 0 && q.lvl <= top_level()
                && q.x < lvl_w(q.lvl) && q.y < lvl_h(q.lvl)
                && texel_addr(q.lvl, q.x, q.y) < STORE_DEPTH)
                texels[texel_addr(q.lvl, q.x, q.y)] = q.c;
        end
        else
            pending_colors.push_back(known ? want : filtered_color(q));
    endtask

    // Offer one item, hold it until taken, then maybe pause
    task automatic drive(req_t q, bit known, color_t want);
        in_valid     <= 1'b1;
        mode         <= q.mode;
        coord_u      <= q.u;
        coord_v      <= q.v;
        detail_level <= q.lod;
        load_level   <= q.lvl;
        load_x       <= q.x;
        load_y       <= q.y;
        in_red       <= q.c.red;
        in_green     <= q.c.green;
        in_blue      <= q.c.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb(q, known, want);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Let the pipeline empty, including trailing loads
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        case (idx)
            REG_SAMPLER_MODE: sh_mode = val[1:0];
            REG_BASE_WIDTH:   sh_w = val;
            default:          sh_h = val;
        endcase
    endtask

    function automatic logic signed [17:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 18'(int'($urandom_range(0, 65536)));
            5:
                case ($urandom_range(0, 5))
                    0: return 18'sd0;
                    1: return 18'sd65536;
                    2: return -18'sd1;
                    3: return 18'sd65537;
                    4: return -18'sd131072;
                    default: return 18'sd131071;
                endcase
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic req_t sample_req(logic signed [17:0] u, logic signed [17:0] v,
                                        logic signed [12:0] lod);
        return '{1'b0, u, v, lod, 3'd0, 7'd0, 7'd0, color_t'(0)};
    endfunction

    function automatic req_t load_req(int unsigned k, int unsigned x, int unsigned y, color_t c);
        return '{1'b1, 18'($urandom), 18'($urandom), 13'($urandom), 3'(k), 7'(x), 7'(y), c};
    endfunction

    function automatic row_t smp(logic signed [17:0] u, logic signed [17:0] v,
                                 logic signed [12:0] lod, bit known, color_t want);
        return '{ROW_REQ, 2'd0, 8'd0, sample_req(u, v, lod), known, want};
    endfunction

    function automatic row_t ld(int unsigned k, int unsigned x, int unsigned y, color_t c);
        return '{ROW_REQ, 2'd0, 8'd0, load_req(k, x, y, c), 1'b0, color_t'(0)};
    endfunction

    function automatic row_t cfg(logic [1:0] idx, logic [7:0] val);
        return '{ROW_CFG, idx, val, req_t'(0), 1'b0, color_t'(0)};
    endfunction

    // Configure, fill every level, then stream random samples and loads
    task automatic run_phase(logic [1:0] sm, logic [7:0] w, logic [7:0] h, int samples,
                             bit with_hold);
        int unsigned n;
        int unsigned k;
        drain();
        write_reg(REG_SAMPLER_MODE, sm);
        write_reg(REG_BASE_WIDTH, w);
        write_reg(REG_BASE_HEIGHT, h);
        cfg_write_en <= 1'b0;
        repeat (4) @(posedge clk);
        n = top_level();
        if (eff_w() != 0 && eff_h() != 0)
            for (int unsigned lv = 0; lv <= n; lv++)
                for (int unsigned y = 0; y < lvl_h(lv); y++)
                    for (int unsigned x = 0; x < lvl_w(lv); x++)
                        drive(load_req(lv, x, y, color_t'({$urandom, $urandom})), 0, '0);
        for (int i = 0; i < samples; i++)
        begin
            if (with_hold && i == samples / 2)
                hold_req = 1'b1;
            case ($urandom_range(0, 19))
                0, 1:
                begin
                    k = $urandom_range(0, n);
                    drive(load_req(k, $urandom_range(0, lvl_w(k) - 1),
                                   $urandom_range(0, lvl_h(k) - 1),
                                   color_t'({$urandom, $urandom})), 0, '0);
                end
                2: drive(load_req($urandom_range(0, 7), $urandom_range(0, 127),
                                  $urandom_range(0, 127), color_t'({$urandom, $urandom})),
                         0, '0);
                default:
                    drive(sample_req(pick_coord(), pick_coord(),
                                     $urandom_range(0, 7) == 0 ? 13'($urandom)
                                         : 13'(int'($urandom_range(0, (n + 2) * 256)) - 256)),
                          0, '0);
            endcase
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, none when quiet
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each delivered item with the oldest expected color
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("unexpected result red=%h green=%h blue=%h", out_red, out_green, out_blue);
                errors++;
            end
            else
            begin
                color_t e;
                e = pending_colors.pop_front();
                if (out_red !== e.red)
                begin
                    $error("out_red expected %h actual %h", e.red, out_red);
                    errors++;
                end
                if (out_green !== e.green)
                begin
                    $error("out_green expected %h actual %h", e.green, out_green);
                    errors++;
                end
                if (out_blue !== e.blue)
                begin
                    $error("out_blue expected %h actual %h", e.blue, out_blue);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        row_t plan [19];
        for (int i = 0; i < STORE_DEPTH; i++)
            texels[i] = '0;
        plan = '{
            smp(18'sd0, 18'sd0, 13'sd0, 1, '0),
            smp(18'sd131071, -18'sd131072, -13'sd4096, 1, '0),
            ld(7, 127, 127, 48'hffff_ffff_ffff),
            cfg(REG_SAMPLER_MODE, SMODE_NEAREST),
            cfg(REG_BASE_WIDTH, 8'd1),
            cfg(REG_BASE_HEIGHT, 8'd1),
            ld(0, 0, 0, 48'h8000_0000_ffff),
            smp(-18'sd131072, -18'sd131072, 13'sd0, 1, 48'h8000_0000_ffff),
            smp(18'sd131071, 18'sd131071, 13'sd4095, 1, 48'h8000_0000_ffff),
            cfg(REG_SAMPLER_MODE, SM_TRILINEAR),
            smp(18'sd65536, 18'sd0, 13'sd4095, 1, 48'h8000_0000_ffff),
            smp(18'sd32768, 18'sd32768, -13'sd4096, 1, 48'h8000_0000_ffff),
            cfg(REG_SAMPLER_MODE, SM_BILINEAR),
            ld(0, 1, 0, 48'h0000_0000_0000),
            ld(1, 0, 0, 48'h0000_0000_0000),
            smp(18'sd32768, 18'sd65535, 13'sd0, 1, 48'h8000_0000_ffff),
            cfg(REG_SAMPLER_MODE, SM_TRI_ALT),
            ld(0, 0, 0, 48'h0001_ffff_0000),
            smp(18'sd1, 18'sd65536, 13'sd256, 1, 48'h0001_ffff_0000)
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: registers are changed only with the pipeline empty
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                cfg_write_en <= 1'b0;
                repeat (4) @(posedge clk);
            end
            else
                drive(plan[i].req, plan[i].known, plan[i].want);
        end

        run_phase(SMODE_NEAREST, 8'd3, 8'd5, 110, 0);
        run_phase(SM_BILINEAR, 8'd7, 8'd2, 110, 0);
        run_phase(SM_TRILINEAR, 8'd16, 8'd8, 140, 1);
        run_phase(SM_TRI_ALT, 8'd200, 8'd1, 110, 0);
        run_phase(SM_TRILINEAR, 8'd1, 8'd128, 110, 0);
        run_phase(SM_BILINEAR, 8'd255, 8'd0, 40, 0);
        quiet = 1'b1;
        run_phase(SM_TRILINEAR, 8'd5, 8'd9, 110, 0);

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* texture_sampler_mip_filter_unit.f */
+incdir+sv
sv/tsm_pkg.sv
sv/tsm_ram.sv
sv/tsm_front.sv
sv/tsm_filter.sv
sv/texture_sampler_mip_filter_unit.sv
sv/tsm_checker.sv
bench/tb.sv
